// ----- sv/crc16_frame_receiver_core_defines.svh -----
// assertion macros shared by the frame receiver modules
`ifndef CRC16_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CRC16_FRAME_RECEIVER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CRCFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crc16 frame receiver assertion failed");
`define CRCFR_ASSERT_NEVER(lbl, clk, rst, cond) \
  `CRCFR_ASSERT(lbl, clk, rst, !(cond))
`else
`define CRCFR_ASSERT(lbl, clk, rst, prop)
`define CRCFR_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ----- sv/crcfr_pkg.sv -----
// shared types, constants and the crc step function of the frame receiver
package crcfr_pkg;

  localparam int MAX_FRAME_DEF = 128;
  localparam logic [7:0] MIN_FRAME = 8'd6;
  localparam logic [7:0] FIELDS_LEN = 8'd5;
  localparam logic [7:0] CRC_LAST_IDX = 8'd4;
  localparam logic [7:0] TYPE_READ_IDX = 8'd3;
  localparam int TYPE_POS = 2;
  localparam logic [7:0] COUNT_SAT = 8'hFF;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_HEADER  = 3'd0,
    REG_VERSION = 3'd1,
    REG_A_CODE  = 3'd2,
    REG_A_LEN   = 3'd3,
    REG_B_CODE  = 3'd4,
    REG_B_LEN   = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_VERSION = 4'b0010,
    PH_FIELDS  = 4'b0100,
    PH_BODY    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] version_byte;
    logic [7:0] type_a_code;
    logic [7:0] type_a_length;
    logic [7:0] type_b_code;
    logic [7:0] type_b_length;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
  } res_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/crcfr_byte_if.sv -----
// received byte channel
interface crcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/crcfr_result_if.sv -----
// frame result channel
interface crcfr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  frame_length;
  logic [15:0] crc_received;
  logic [15:0] crc_computed;
  modport source (output valid, output status, output frame_type, output frame_length,
                  output crc_received, output crc_computed, input ready);
  modport sink (input valid, input status, input frame_type, input frame_length,
                input crc_received, input crc_computed, output ready);
endinterface

// ----- sv/crcfr_cfg_if.sv -----
// configuration write channel
interface crcfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/crcfr_ram.sv -----
// generic single write port ram with registered read
module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/crcfr_regs.sv -----
// configuration register file
module crcfr_regs
  import crcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  crcfr_cfg_if.sink   cfg,
  output cfg_t        regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_HEADER:  regs.header_byte <= cfg.data;
        REG_VERSION: regs.version_byte <= cfg.data;
        REG_A_CODE:  regs.type_a_code <= cfg.data;
        REG_A_LEN:   regs.type_a_length <= cfg.data;
        REG_B_CODE:  regs.type_b_code <= cfg.data;
        REG_B_LEN:   regs.type_b_length <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/crcfr_parser.sv -----
// frame parser: phase tracking, crc, frame store and header checks
`include "crc16_frame_receiver_core_defines.svh"
module crcfr_parser
  import crcfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  input  logic       acc,
  input  logic [7:0] b,
  output logic       res_valid,
  output res_t       res_data
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam logic [7:0] MaxLen = 8'(MAX_FRAME);
  localparam logic [AW-1:0] TypeAddr = AW'(TYPE_POS);

  phase_t      phase, phase_next;
  logic [7:0]  byte_count, count_next;
  logic [7:0]  expected_length, exp_next;
  logic [7:0]  latched_type, type_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  prev_byte;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;

  logic [15:0] crc_upd, crc_start, crc_swap, crc_rx;
  logic [7:0]  cnt_inc, tbl_len;
  logic        fits, known, hdr_ok;

  crcfr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b),
    .re    (ram_re),
    .raddr (TypeAddr),
    .rdata (ram_rdata)
  );

  assign crc_upd   = crc16_step(crc, b);
  assign crc_start = crc16_step(CRC_INIT, b);
  assign crc_swap  = {crc[7:0], crc[15:8]};
  assign crc_rx    = {b, prev_byte};
  assign cnt_inc   = (byte_count != COUNT_SAT) ? byte_count + 8'd1 : byte_count;
  assign fits      = byte_count < MaxLen;

  always_comb begin
    known = 1'b1;
    tbl_len = '0;
    if (ram_rdata == regs.type_a_code) begin
      tbl_len = regs.type_a_length;
    end else if (ram_rdata == regs.type_b_code) begin
      tbl_len = regs.type_b_length;
    end else begin
      known = 1'b0;
    end
    hdr_ok = known && ({b, prev_byte} == {8'd0, tbl_len})
             && (tbl_len >= MIN_FRAME) && (tbl_len <= MaxLen);
  end

  always_comb begin
    phase_next = phase;
    count_next = byte_count;
    exp_next   = expected_length;
    type_next  = latched_type;
    crc_next   = crc;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = byte_count[AW-1:0];
    res_valid  = 1'b0;
    res_data   = '{status: ST_BAD, frame_type: latched_type, frame_length: cnt_inc,
                   crc_received: '0, crc_computed: '0};
    if (acc) begin
      unique case (phase)
        PH_VERSION: begin
          if (b == regs.version_byte) begin
            ram_we     = fits;
            count_next = cnt_inc;
            crc_next   = crc_upd;
            phase_next = PH_FIELDS;
          end else if (b == regs.header_byte) begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            count_next = 8'd1;
            crc_next   = crc_start;
            phase_next = PH_VERSION;
          end else begin
            phase_next = PH_HEADER;
            count_next = '0;
          end
        end
        PH_FIELDS: begin
          ram_we     = fits;
          count_next = cnt_inc;
          ram_re     = (byte_count == TYPE_READ_IDX);
          if (byte_count < CRC_LAST_IDX) begin
            crc_next = crc_upd;
          end
          if (cnt_inc >= FIELDS_LEN) begin
            type_next = ram_rdata;
            if (!hdr_ok) begin
              res_valid           = 1'b1;
              res_data.frame_type = ram_rdata;
              phase_next          = PH_HEADER;
              count_next          = '0;
            end else begin
              exp_next   = tbl_len;
              phase_next = PH_BODY;
              if (tbl_len > MIN_FRAME) begin
                crc_next = crc_upd;
              end
            end
          end
        end
        PH_BODY: begin
          ram_we     = fits;
          count_next = cnt_inc;
          if (({1'b0, byte_count} + 9'd2) < {1'b0, expected_length}) begin
            crc_next = crc_upd;
          end
          if (cnt_inc >= expected_length || cnt_inc >= MaxLen) begin
            res_valid             = 1'b1;
            res_data.status       = (crc_rx == crc_swap) ? ST_OK : ST_CRC;
            res_data.crc_received = crc_rx;
            res_data.crc_computed = crc_swap;
            phase_next            = PH_HEADER;
            count_next            = '0;
          end
        end
        default: begin
          if (b == regs.header_byte) begin
            ram_we     = 1'b1;
            ram_waddr  = '0;
            count_next = 8'd1;
            crc_next   = crc_start;
            phase_next = PH_VERSION;
          end else begin
            phase_next = PH_HEADER;
            count_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_count      <= '0;
      expected_length <= '0;
      latched_type    <= '0;
      crc             <= CRC_INIT;
    end else begin
      phase           <= phase_next;
      byte_count      <= count_next;
      expected_length <= exp_next;
      latched_type    <= type_next;
      crc             <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_byte <= b;
    end
  end

  `CRCFR_ASSERT(a_idle_count, clk, rst, (phase == PH_HEADER) |-> (byte_count == 8'd0))
  `CRCFR_ASSERT(a_body_bound, clk, rst, (phase == PH_BODY) |-> (byte_count < expected_length))
  `CRCFR_ASSERT(a_ok_match, clk, rst, (res_valid && res_data.status == ST_OK) |-> (res_data.crc_received == res_data.crc_computed))
  `CRCFR_ASSERT_NEVER(a_res_no_acc, clk, rst, res_valid && !acc)

endmodule

// ----- sv/crcfr_outq.sv -----
// two entry result queue between parser and result channel
`include "crc16_frame_receiver_core_defines.svh"
module crcfr_outq
  import crcfr_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  res_t           push_data,
  output logic           full,
  crcfr_result_if.source res
);

  logic [1:0] count;
  res_t       slot0, slot1;
  logic       pop;

  assign full = (count == 2'd2);
  assign pop  = res.valid && res.ready;

  assign res.valid        = (count != 2'd0);
  assign res.status       = slot0.status;
  assign res.frame_type   = slot0.frame_type;
  assign res.frame_length = slot0.frame_length;
  assign res.crc_received = slot0.crc_received;
  assign res.crc_computed = slot0.crc_computed;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      slot0 <= push_data;
    end else if (pop && count == 2'd2) begin
      slot0 <= slot1;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      slot1 <= push_data;
    end
  end

  `CRCFR_ASSERT_NEVER(a_count_range, clk, rst, count == 2'd3)
  `CRCFR_ASSERT_NEVER(a_no_overflow, clk, rst, push && full)

endmodule

// ----- sv/crc16_frame_receiver_core.sv -----
// crc16 framed packet receiver, top level
// usage: received bytes enter on rx, one transaction per byte; results leave on res,
// one transaction per finished frame or frame rejected at its header fields;
// registers are written on cfg (index 0 header, 1 version, 2/3 type a code/length,
// 4/5 type b code/length; other indexes are ignored), by the user only while no
// frame is in progress; the block itself does not enforce it. throughput: one
// byte per cycle while rx.ready is high; the crc step, phase update and frame
// store write all complete in the cycle a byte is taken. a frame's result is
// registered in the result queue when its last byte (or its fifth byte on a
// rejected header) is taken, and shows on res behind any results waiting there.
// the frame store is a single ram; the type byte is read one byte ahead so the
// table lookup is done as the fifth byte is taken. a two entry result queue lets
// bytes keep flowing while a result waits; rx.ready drops whenever both entries
// are held. reset: synchronous, clears registers to zero, parser back to waiting
// for a header, crc to all ones, queue empty; the frame store needs no clearing.
module crc16_frame_receiver_core
  import crcfr_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic           clk,
  input  logic           rst,
  crcfr_cfg_if.sink      cfg,
  crcfr_byte_if.sink     rx,
  crcfr_result_if.source res
);

  cfg_t regs;
  logic acc, full, res_valid;
  res_t res_data;

  assign rx.ready = !full;
  assign acc = rx.valid && rx.ready;

  crcfr_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  crcfr_parser #(.MAX_FRAME(MAX_FRAME)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .acc       (acc),
    .b         (rx.rx_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  crcfr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .full      (full),
    .res       (res)
  );

endmodule

// ----- tb/sv/tb_crc16_frame_receiver_core.sv -----
// testbench for the crc16 frame receiver: scripted and random byte streams checked by a parser model
module tb_crc16_frame_receiver_core;
  import crcfr_pkg::*;

  localparam int FRAME_CAP = 128;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASE_BYTES = 310;
  localparam int NUM_PHASES = 6;
  localparam int SCRIPT_ROWS = 28;
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef enum logic [1:0] {
    ROW_DATA,
    ROW_TYPED,
    ROW_CRC_LO,
    ROW_CRC_HI
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    res_t       result;
  } script_row_t;

  logic clk;
  logic rst;

  crcfr_cfg_if    cfg_if ();
  crcfr_byte_if   rx_if ();
  crcfr_result_if res_if ();

  crc16_frame_receiver_core u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .rx  (rx_if),
    .res (res_if)
  );

  // parser model state
  cfg_t        shadow_cfg;
  phase_t      rx_phase;
  logic [7:0]  rx_count;
  logic [7:0]  frame_len_target;
  logic [7:0]  held_type;
  logic [15:0] crc_acc;
  logic [7:0]  byte_store [0:FRAME_CAP-1];

  res_t        pending_results [$];
  script_row_t frame_script [0:SCRIPT_ROWS-1];

  bit allow_idle;
  bit rx_gaps;
  bit res_stalls;
  int err_count;
  int byte_total;
  int frames_ok;
  int frames_crc;
  int frames_bad;
  int setting_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] modbus_crc_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic report_err(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic store_byte(input logic [7:0] b);
    if (rx_count < FRAME_CAP) byte_store[rx_count[6:0]] = b;
    if (rx_count != COUNT_SAT) rx_count = rx_count + 8'd1;
  endtask

  task automatic open_frame(input logic [7:0] b);
    rx_count = 8'd0;
    store_byte(b);
    crc_acc = modbus_crc_next(CRC_INIT, b);
    rx_phase = PH_VERSION;
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit produced, output res_t r);
    int pos;
    int limit;
    int n;
    bit known;
    logic [15:0] declared;
    logic [15:0] got_crc;
    logic [15:0] own_crc;
    produced = 1'b0;
    r = '0;
    case (rx_phase)
      PH_VERSION: begin
        if (b == shadow_cfg.version_byte) begin
          store_byte(b);
          crc_acc = modbus_crc_next(crc_acc, b);
          rx_phase = PH_FIELDS;
        end else if (b == shadow_cfg.header_byte) begin
          open_frame(b);
        end else begin
          rx_phase = PH_HEADER;
          rx_count = 8'd0;
        end
      end
      PH_FIELDS: begin
        pos = int'(rx_count);
        store_byte(b);
        if (pos < CRC_LAST_IDX) crc_acc = modbus_crc_next(crc_acc, b);
        if (rx_count >= FIELDS_LEN) begin
          held_type = byte_store[TYPE_POS];
          declared = {b, byte_store[TYPE_READ_IDX]};
          known = 1'b1;
          if (held_type == shadow_cfg.type_a_code) begin
            limit = int'(shadow_cfg.type_a_length);
          end else if (held_type == shadow_cfg.type_b_code) begin
            limit = int'(shadow_cfg.type_b_length);
          end else begin
            limit = 0;
            known = 1'b0;
          end
          if (!known || declared != limit || limit < MIN_FRAME || limit > FRAME_CAP) begin
            produced = 1'b1;
            r.status = ST_BAD;
            r.frame_type = held_type;
            r.frame_length = rx_count;
            r.crc_received = 16'h0000;
            r.crc_computed = 16'h0000;
            rx_phase = PH_HEADER;
            rx_count = 8'd0;
          end else begin
            frame_len_target = limit[7:0];
            if (limit > MIN_FRAME) crc_acc = modbus_crc_next(crc_acc, b);
            rx_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        pos = int'(rx_count);
        store_byte(b);
        if (pos + 2 < frame_len_target) crc_acc = modbus_crc_next(crc_acc, b);
        if (rx_count >= frame_len_target || rx_count >= FRAME_CAP) begin
          n = int'(rx_count);
          got_crc = {byte_store[(n - 1) % FRAME_CAP], byte_store[(n - 2) % FRAME_CAP]};
          own_crc = {crc_acc[7:0], crc_acc[15:8]};
          produced = 1'b1;
          r.status = (got_crc == own_crc) ? ST_OK : ST_CRC;
          r.frame_type = held_type;
          r.frame_length = rx_count;
          r.crc_received = got_crc;
          r.crc_computed = own_crc;
          rx_phase = PH_HEADER;
          rx_count = 8'd0;
        end
      end
      default: begin
        if (b == shadow_cfg.header_byte) begin
          open_frame(b);
        end else begin
          rx_phase = PH_HEADER;
          rx_count = 8'd0;
        end
      end
    endcase
  endtask

  task automatic send_rx(input logic [7:0] b, input bit use_typed, input res_t typed);
    bit produced;
    res_t r;
    int gap;
    @(negedge clk);
    if (rx_gaps && $urandom_range(0, 7) == 0) begin
      rx_if.valid = 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    rx_if.valid = 1'b1;
    rx_if.rx_byte = b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    parse_byte(b, produced, r);
    if (produced) pending_results.push_back(use_typed ? typed : r);
    byte_total++;
  endtask

  task automatic wait_drained;
    int waited;
    waited = 0;
    @(negedge clk);
    rx_if.valid = 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic close_frame;
    logic [7:0] fill;
    while (rx_phase != PH_HEADER) begin
      fill = 8'($urandom_range(0, 255));
      if (rx_phase == PH_VERSION) begin
        while (fill == shadow_cfg.header_byte || fill == shadow_cfg.version_byte)
          fill = 8'($urandom_range(0, 255));
      end
      send_rx(fill, 1'b0, '0);
    end
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_HEADER:  shadow_cfg.header_byte = val;
      REG_VERSION: shadow_cfg.version_byte = val;
      REG_A_CODE:  shadow_cfg.type_a_code = val;
      REG_A_LEN:   shadow_cfg.type_a_length = val;
      REG_B_CODE:  shadow_cfg.type_b_code = val;
      REG_B_LEN:   shadow_cfg.type_b_length = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] hdr, input logic [7:0] ver,
                                input logic [7:0] a_code, input logic [7:0] a_len,
                                input logic [7:0] b_code, input logic [7:0] b_len);
    close_frame();
    wait_drained();
    cfg_write(REG_HEADER, hdr);
    cfg_write(REG_VERSION, ver);
    cfg_write(REG_A_CODE, a_code);
    cfg_write(REG_A_LEN, a_len);
    cfg_write(REG_B_CODE, b_code);
    cfg_write(REG_B_LEN, b_len);
    setting_count++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] declared,
                            input int total, input int keep, input bit corrupt,
                            input bit extra_header);
    logic [7:0] q [$];
    logic [15:0] acc;
    int i;
    int k;
    if (extra_header) send_rx(shadow_cfg.header_byte, 1'b0, '0);
    q.push_back(shadow_cfg.header_byte);
    q.push_back(shadow_cfg.version_byte);
    q.push_back(ftype);
    q.push_back(declared[7:0]);
    q.push_back(declared[15:8]);
    if (total >= MIN_FRAME && total <= FRAME_CAP) begin
      while (q.size() < total - 2) q.push_back(8'($urandom_range(0, 255)));
      acc = CRC_INIT;
      for (i = 0; i < total - 2; i++) acc = modbus_crc_next(acc, q[i]);
      // low crc byte goes last
      if (q.size() == total - 2) q.push_back(acc[15:8]);
      q.push_back(acc[7:0]);
      if (corrupt) begin
        k = $urandom_range(0, 7);
        q[q.size() - 1] = q[q.size() - 1] ^ (8'h01 << k);
      end
    end
    if (keep == 0 || keep > q.size()) keep = q.size();
    for (i = 0; i < keep; i++) send_rx(q[i], 1'b0, '0);
  endtask

  task automatic run_random(input int budget);
    int start;
    int pick;
    int total;
    int n;
    bit which;
    logic [7:0] code;
    logic [7:0] ftype;
    logic [15:0] declared;
    start = byte_total;
    while (byte_total - start < budget) begin
      pick = $urandom_range(0, 99);
      which = 1'($urandom_range(0, 1));
      code = which ? shadow_cfg.type_b_code : shadow_cfg.type_a_code;
      total = int'(which ? shadow_cfg.type_b_length : shadow_cfg.type_a_length);
      if (pick < 70) begin
        send_frame(code, 16'(total), total, 0, $urandom_range(0, 6) == 0, 1'b0);
      end else if (pick < 78) begin
        ftype = 8'($urandom_range(0, 255));
        while (ftype == shadow_cfg.type_a_code || ftype == shadow_cfg.type_b_code)
          ftype = 8'($urandom_range(0, 255));
        send_frame(ftype, 16'(total), total, FIELDS_LEN, 1'b0, 1'b0);
      end else if (pick < 84) begin
        declared = 16'($urandom_range(0, 65535));
        if (declared == total) declared = declared ^ 16'h0100;
        send_frame(code, declared, total, FIELDS_LEN, 1'b0, 1'b0);
      end else if (pick < 89) begin
        ftype = 8'($urandom_range(0, 255));
        while (ftype == shadow_cfg.version_byte || ftype == shadow_cfg.header_byte)
          ftype = 8'($urandom_range(0, 255));
        send_rx(shadow_cfg.header_byte, 1'b0, '0);
        send_rx(ftype, 1'b0, '0);
      end else if (pick < 92) begin
        send_frame(code, 16'(total), total, 0, 1'b0, 1'b1);
      end else if (pick < 95) begin
        send_frame(code, 16'(total), total, $urandom_range(1, 12), 1'b0, 1'b0);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_rx(8'($urandom_range(0, 255)), 1'b0, '0);
      end
      if ($urandom_range(0, 59) == 0) wait_drained();
      if ($urandom_range(0, 19) == 0) begin
        rx_gaps = allow_idle && ($urandom_range(0, 3) != 0);
        res_stalls = allow_idle && ($urandom_range(0, 3) != 0);
      end
    end
  endtask

  always @(posedge clk) begin : res_check
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_err($sformatf("unexpected transaction: status %0d type %02h length %0d",
                             res_if.status, res_if.frame_type, res_if.frame_length));
      end else begin
        want = pending_results.pop_front();
        if (res_if.status !== want.status)
          report_err($sformatf("status got %0d exp %0d", res_if.status, want.status));
        if (res_if.frame_type !== want.frame_type)
          report_err($sformatf("frame_type got %02h exp %02h",
                               res_if.frame_type, want.frame_type));
        if (res_if.frame_length !== want.frame_length)
          report_err($sformatf("frame_length got %0d exp %0d",
                               res_if.frame_length, want.frame_length));
        if (res_if.crc_received !== want.crc_received)
          report_err($sformatf("crc_received got %04h exp %04h",
                               res_if.crc_received, want.crc_received));
        if (res_if.crc_computed !== want.crc_computed)
          report_err($sformatf("crc_computed got %04h exp %04h",
                               res_if.crc_computed, want.crc_computed));
        case (want.status)
          ST_OK:   frames_ok++;
          ST_CRC:  frames_crc++;
          default: frames_bad++;
        endcase
      end
    end
  end

  initial begin : res_pacing
    int hold;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (res_stalls && $urandom_range(0, 9) == 0) begin
        res_if.ready = 1'b0;
        hold = $urandom_range(1, 19);
        repeat (hold - 1) @(negedge clk);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] v;
    logic [7:0] a_len;
    logic [7:0] b_len;
    int waited;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_HEADER;
    cfg_if.data = 8'h00;
    shadow_cfg = '0;
    rx_phase = PH_HEADER;
    rx_count = 8'd0;
    frame_len_target = 8'd0;
    held_type = 8'd0;
    crc_acc = CRC_INIT;
    allow_idle = 1'b1;
    rx_gaps = 1'b1;
    res_stalls = 1'b1;
    err_count = 0;
    byte_total = 0;
    frames_ok = 0;
    frames_crc = 0;
    frames_bad = 0;
    setting_count = 0;
    frame_script = '{
      // wrong first byte
      '{ROW_DATA, 8'h55, '0},
      // repeated header, then a good frame with an all-ones payload byte
      '{ROW_DATA, 8'hAA, '0}, '{ROW_DATA, 8'hAA, '0}, '{ROW_DATA, 8'h01, '0},
      '{ROW_DATA, 8'h10, '0}, '{ROW_DATA, 8'h08, '0}, '{ROW_DATA, 8'h00, '0},
      '{ROW_DATA, 8'hFF, '0}, '{ROW_CRC_HI, 8'h00, '0}, '{ROW_CRC_LO, 8'h00, '0},
      // wrong version byte
      '{ROW_DATA, 8'hAA, '0}, '{ROW_DATA, 8'h33, '0},
      // unknown type
      '{ROW_DATA, 8'hAA, '0}, '{ROW_DATA, 8'h01, '0}, '{ROW_DATA, 8'h77, '0},
      '{ROW_DATA, 8'h08, '0},
      '{ROW_TYPED, 8'h00, '{ST_BAD, 8'h77, 8'd5, 16'h0000, 16'h0000}},
      // declared length off by the high byte
      '{ROW_DATA, 8'hAA, '0}, '{ROW_DATA, 8'h01, '0}, '{ROW_DATA, 8'h10, '0},
      '{ROW_DATA, 8'h08, '0},
      '{ROW_TYPED, 8'h01, '{ST_BAD, 8'h10, 8'd5, 16'h0000, 16'h0000}},
      // six byte frame, length high byte shared with the crc
      '{ROW_DATA, 8'hAA, '0}, '{ROW_DATA, 8'h01, '0}, '{ROW_DATA, 8'h20, '0},
      '{ROW_DATA, 8'h06, '0}, '{ROW_DATA, 8'h00, '0}, '{ROW_CRC_LO, 8'h00, '0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apply_settings(8'hAA, 8'h01, 8'h10, 8'd8, 8'h20, 8'd6);
    cfg_write(REG_SPARE_6, 8'h5A);
    cfg_write(REG_SPARE_7, 8'hFF);
    foreach (frame_script[i]) begin
      case (frame_script[i].kind)
        ROW_CRC_LO: v = crc_acc[7:0];
        ROW_CRC_HI: v = crc_acc[15:8];
        default:    v = frame_script[i].value;
      endcase
      send_rx(v, frame_script[i].kind == ROW_TYPED, frame_script[i].result);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      a_len = ($urandom_range(0, 5) == 0) ? 8'd128 : 8'($urandom_range(6, 24));
      b_len = ($urandom_range(0, 5) == 0) ? 8'd128 : 8'($urandom_range(6, 24));
      case (p)
        0: apply_settings(8'hFF, 8'h00, 8'h00, 8'd128, 8'hFF, 8'd6);
        1: apply_settings(8'h00, 8'h00, 8'h5A, 8'd7, 8'h5A, 8'd9);
        2: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'd0,
                          8'($urandom_range(0, 255)), 8'($urandom_range(6, 20)));
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), a_len,
                                8'($urandom_range(0, 255)), b_len);
      endcase
      if (p == 3) cfg_write(REG_SPARE_6, 8'h00);
      allow_idle = (p != NUM_PHASES - 1);
      rx_gaps = allow_idle;
      res_stalls = allow_idle;
      run_random(PHASE_BYTES);
    end

    @(negedge clk);
    rx_if.valid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_err($sformatf("%0d results never arrived", pending_results.size()));

    $display("run covered %0d bytes over %0d register settings", byte_total, setting_count);
    $display("frames seen: %0d good, %0d crc errors, %0d rejected at the header fields",
             frames_ok, frames_crc, frames_bad);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/crcfr_pkg.sv
sv/crcfr_byte_if.sv
sv/crcfr_result_if.sv
sv/crcfr_cfg_if.sv
sv/crcfr_ram.sv
sv/crcfr_regs.sv
sv/crcfr_parser.sv
sv/crcfr_outq.sv
sv/crc16_frame_receiver_core.sv
tb/sv/tb_crc16_frame_receiver_core.sv
